// ===== hw/rtl/rpbs_pkg.sv =====
// shared constants and types for the ready priority bitmap scheduler
`timescale 1ns / 1ps

package rpbs_pkg;

  // defaults for the top level parameters
  localparam int NUM_LEVELS_DEF = 256;
  localparam int COUNT_MAX_DEF  = 255;

  // bitmap word layout: level p is bit (p & 0x1f) of word (p >> 5)
  localparam int WORD_SHIFT = 5;
  localparam int WORD_BITS  = 1 << WORD_SHIFT;

  // fixed field widths of the ports
  localparam int LEVEL_W     = 8;
  localparam int COUNT_OUT_W = 8;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  // priority encoder result
  typedef struct packed {
    logic               any;
    logic [LEVEL_W-1:0] idx;
  } enc_result_t;

endpackage

// ===== hw/rtl/ready_priority_bitmap_scheduler_unit.sv =====
// ready priority bitmap scheduler: per-level counts, ready bitmap, urgent level
`timescale 1ns / 1ps
// a taken word passes the input stage, then the result register, where it is offered
// throughput: one word per cycle unless the output stalls; count memory read in the
//   input stage, count update, bitmap update and lowest-bit encode in the second stage
// reset (rst_n low, synchronous): bitmap, count valid bits and both stage valids clear
//   at once; count memory contents are not cleared, the valid bits mask them

module ready_priority_bitmap_scheduler_unit import rpbs_pkg::*; #(
  parameter int NUM_LEVELS = NUM_LEVELS_DEF,
  parameter int COUNT_MAX  = COUNT_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_action,
  input  logic [LEVEL_W-1:0]     in_priority_req,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [LEVEL_W-1:0]     out_highest_ready,
  output logic                   out_any_ready,
  output logic [COUNT_OUT_W-1:0] out_level_count,
  output logic [1:0]             out_error_code
);

  localparam int          ADDR_W       = $clog2(NUM_LEVELS);
  localparam int          COUNT_W      = $clog2(COUNT_MAX + 1);
  localparam logic [9:0]  NUM_LEVELS_V = 10'(NUM_LEVELS);
  localparam logic [COUNT_W-1:0] COUNT_MAX_V = COUNT_W'(COUNT_MAX);

  // action codes
  localparam logic ACT_INSERT = 1'b0;

  // input stage
  logic               s1_vld_r;
  logic               act_r;
  logic [LEVEL_W-1:0] lvl_r;

  // result stage
  logic                   out_vld_r;
  logic [LEVEL_W-1:0]     hi_r;
  logic                   any_r;
  logic [COUNT_OUT_W-1:0] cnt_out_r;
  err_t                   err_r;

  // ready bitmap, one bit per level
  logic [NUM_LEVELS-1:0] bitmap_r;
  logic [NUM_LEVELS-1:0] bitmap_nxt;

  logic               advance;
  logic               accept;
  logic               fire;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  s1_addr;
  logic               in_range;
  logic [COUNT_W-1:0] cur_cnt;
  logic [COUNT_W-1:0] new_cnt;
  logic [COUNT_W-1:0] res_cnt;
  logic               upd;
  err_t               err_nxt;
  logic [COUNT_OUT_W-1:0] cnt_out_nxt;
  enc_result_t        enc;

  // result register frees when empty or being taken
  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !s1_vld_r || advance;
  assign accept   = in_valid && in_ready;
  assign fire     = s1_vld_r && advance;

  assign rd_addr  = ADDR_W'({2'b00, in_priority_req});
  assign s1_addr  = ADDR_W'({2'b00, lvl_r});
  assign in_range = ({2'b00, lvl_r} < NUM_LEVELS_V);

  rpbs_count_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (COUNT_W)
  ) u_count_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (cur_cnt),
    .wr_en   (fire && upd),
    .wr_addr (s1_addr),
    .wr_data (new_cnt)
  );

  // count update for the word in the input stage
  always_comb begin
    upd     = 1'b0;
    err_nxt = ERR_OK;
    new_cnt = cur_cnt;
    res_cnt = cur_cnt;
    if (!in_range) begin
      // level outside the table holds nothing and has no room
      err_nxt = (act_r == ACT_INSERT) ? ERR_FULL : ERR_EMPTY;
      res_cnt = '0;
    end else if (act_r == ACT_INSERT) begin
      if (cur_cnt >= COUNT_MAX_V) begin
        err_nxt = ERR_FULL;
      end else begin
        upd     = 1'b1;
        new_cnt = cur_cnt + COUNT_W'(1);
        res_cnt = new_cnt;
      end
    end else begin
      if (cur_cnt == '0) begin
        err_nxt = ERR_EMPTY;
      end else begin
        upd     = 1'b1;
        new_cnt = cur_cnt - COUNT_W'(1);
        res_cnt = new_cnt;
      end
    end
  end

  // reported count saturates at the port width
  always_comb begin
    if (32'(res_cnt) > 32'd255) begin
      cnt_out_nxt = '1;
    end else begin
      cnt_out_nxt = COUNT_OUT_W'(res_cnt);
    end
  end

  // bit set on every accepted insert, cleared when a remove empties the level
  always_comb begin
    bitmap_nxt = bitmap_r;
    if (upd) begin
      if (act_r == ACT_INSERT) begin
        bitmap_nxt[s1_addr] = 1'b1;
      end else if (new_cnt == '0) begin
        bitmap_nxt[s1_addr] = 1'b0;
      end
    end
  end

  rpbs_prio_enc #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_prio_enc (
    .bitmap (bitmap_nxt),
    .res    (enc)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      bitmap_r  <= '0;
    end else begin
      if (accept) begin
        s1_vld_r <= 1'b1;
      end else if (advance) begin
        s1_vld_r <= 1'b0;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
        bitmap_r  <= bitmap_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      lvl_r <= in_priority_req;
    end
    if (fire) begin
      hi_r      <= enc.idx;
      any_r     <= enc.any;
      cnt_out_r <= cnt_out_nxt;
      err_r     <= err_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_highest_ready = hi_r;
  assign out_any_ready     = any_r;
  assign out_level_count   = cnt_out_r;
  assign out_error_code    = err_r;

endmodule

// ===== hw/rtl/rpbs_count_ram.sv =====
// per-level ready count memory with valid bits and write-to-read bypass
`timescale 1ns / 1ps

module rpbs_count_ram import rpbs_pkg::*; #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DATA_W-1:0] mem_rd_r;
  logic              rd_vld_r;
  logic              fwd_r;
  logic [DATA_W-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rd_r   <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
        fwd_r    <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // unwritten entries read as zero
  assign rd_data = fwd_r ? fwd_data_r : (rd_vld_r ? mem_rd_r : '0);

endmodule

// ===== hw/rtl/rpbs_prio_enc.sv =====
// lowest-set-bit encoder over the ready bitmap, word then bit
`timescale 1ns / 1ps

module rpbs_prio_enc import rpbs_pkg::*; #(
  parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
  input  logic [NUM_LEVELS-1:0] bitmap,
  output enc_result_t           res
);

  localparam int NUM_WORDS = (NUM_LEVELS + WORD_BITS - 1) / WORD_BITS;
  localparam int PAD_W     = NUM_WORDS * WORD_BITS;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic [PAD_W-1:0]      padded;
  logic [NUM_WORDS-1:0]  word_any;
  logic [WIDX_W-1:0]     w_idx;
  logic [WORD_BITS-1:0]  sel_word;
  logic [WORD_SHIFT-1:0] b_idx;

  assign padded = PAD_W'(bitmap);

  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      word_any[w] = |padded[w*WORD_BITS +: WORD_BITS];
    end
  end

  // first nonzero word, lowest index wins
  always_comb begin
    w_idx = '0;
    for (int w = NUM_WORDS - 1; w >= 0; w--) begin
      if (word_any[w]) begin
        w_idx = WIDX_W'(w);
      end
    end
  end

  assign sel_word = padded[w_idx*WORD_BITS +: WORD_BITS];

  always_comb begin
    b_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (sel_word[b]) begin
        b_idx = WORD_SHIFT'(b);
      end
    end
  end

  assign res.any = |word_any;
  assign res.idx = LEVEL_W'({w_idx, b_idx});

endmodule

// ===== hw/rtl/rpbs_checker.sv =====
// port-level checks for the ready priority bitmap scheduler, bound to the top level
`timescale 1ns / 1ps

module rpbs_checker import rpbs_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [LEVEL_W-1:0]     out_highest_ready,
  input logic                   out_any_ready,
  input logic [COUNT_OUT_W-1:0] out_level_count,
  input logic [1:0]             out_error_code
);

  // empty scheduler reports level zero
  a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_any_ready |-> out_highest_ready == '0)
    else $error("highest ready level nonzero with nothing ready");

  // only defined error codes appear
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error_code == ERR_OK || out_error_code == ERR_EMPTY ||
                   out_error_code == ERR_FULL))
    else $error("undefined error code");

  // an ignored remove always sees an empty level
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == ERR_EMPTY |-> out_level_count == '0)
    else $error("remove at empty level reports nonzero count");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_highest_ready) &&
      $stable(out_any_ready) && $stable(out_level_count) && $stable(out_error_code))
    else $error("result word changed while stalled");

endmodule

bind ready_priority_bitmap_scheduler_unit rpbs_checker u_rpbs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_highest_ready (out_highest_ready),
  .out_any_ready     (out_any_ready),
  .out_level_count   (out_level_count),
  .out_error_code    (out_error_code)
);
